FILE: hw/rtl/bna_pkg.sv
package bna_pkg;

    localparam int FIELD_W      = 14;
    localparam int WORD_BITS    = 32;
    localparam int WORD_LG      = 5;
    localparam int DEF_MAP_BITS = 8192;
    localparam int RESET_MAP_SIZE   = 8192;
    localparam int RESET_FREE_COUNT = 8192;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    localparam logic REG_MAP_SIZE   = 1'b0;
    localparam logic REG_START_FREE = 1'b1;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_MARK  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic advance;
        logic commit;
        logic clear_wr;
    } ctl_cmd_t;

    typedef struct packed {
        logic done;
        logic clear_last;
    } ctl_status_t;

endpackage

FILE: hw/rtl/bna_ctrl.sv
module bna_ctrl
    import bna_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output ctl_cmd_t    cmd,
    input  ctl_status_t status
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (!status.done) state_next = ST_READ;
                else if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ: cmd.rd = 1'b1;
            ST_EVAL: begin
                cmd.advance = !status.done;
                // hold the finished item until the output register frees up
                cmd.commit  = status.done && out_free;
            end
            default: ;
        endcase
        if (cmd.commit) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
        else m_tvalid_next = m_tvalid_reg;
    end

endmodule

FILE: hw/rtl/bna_dp.sv
module bna_dp
    import bna_pkg::*;
#(
    parameter int MAP_BITS = DEF_MAP_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [FIELD_W-1:0]   cfg_wdata,
    input  ctl_cmd_t             cmd,
    output ctl_status_t          status
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IW        = WA + WORD_LG;
    localparam int CW        = ((IW > FIELD_W) ? IW : FIELD_W) + 1;
    localparam int MAP_CAP   = (MAP_BITS < (2 ** FIELD_W) - 1) ? MAP_BITS : (2 ** FIELD_W) - 1;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];

    logic [FIELD_W-1:0]   map_size_reg, map_size_next;
    logic [FIELD_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [WA-1:0]        hint_reg, hint_next;
    logic [WA-1:0]        word_addr_reg;
    logic [WA-1:0]        clr_addr_reg;
    action_t              act_reg;
    logic [FIELD_W-1:0]   num_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [FIELD_W-1:0]   alloc_num_reg;
    logic                 ok_reg;
    logic [FIELD_W-1:0]   free_left_reg;

    action_t              in_action;
    logic [FIELD_W-1:0]   in_number;
    logic [FIELD_W-1:0]   in_idx;

    logic [FIELD_W-1:0]   bound;
    logic [CW-1:0]        bound_w, base_w, rem;
    logic                 last_word;
    logic [WORD_BITS-1:0] mask, cand, wr_word;
    logic                 found;
    logic [WORD_LG-1:0]   pos;
    logic [FIELD_W-1:0]   num_idx;
    logic [WORD_LG-1:0]   bit_pos;
    logic                 in_range;
    logic                 item_done, item_we, item_ok;
    logic [FIELD_W-1:0]   item_num;
    logic                 mem_we;
    logic [WA-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign in_action = action_t'(s_tdata[1:0]);
    assign in_number = s_tdata[FIELD_W+1:2];
    assign in_idx    = in_number - FIELD_W'(1);

    assign bound   = (map_size_reg > FIELD_W'(MAP_CAP)) ? FIELD_W'(MAP_CAP) : map_size_reg;
    assign bound_w = CW'(bound);
    assign base_w  = CW'({word_addr_reg, WORD_LG'(0)});
    assign rem     = bound_w - base_w;
    assign last_word = rem <= CW'(WORD_BITS);

    assign num_idx  = num_reg - FIELD_W'(1);
    assign bit_pos  = num_idx[WORD_LG-1:0];
    assign in_range = (num_reg != '0) && (num_reg <= bound);

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = CW'(j) < rem;
        end
        cand  = ~rd_word_reg & mask;
        found = |cand;
        pos   = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) pos = WORD_LG'(j);
        end
    end

    always_comb begin
        item_done = 1'b1;
        item_we   = 1'b0;
        item_ok   = 1'b0;
        item_num  = '0;
        wr_word   = rd_word_reg;
        case (act_reg)
            ACT_ALLOC: begin
                item_done = found || last_word;
                item_we   = found;
                item_ok   = found;
                wr_word   = rd_word_reg | (WORD_BITS'(1) << pos);
                if (found) item_num = FIELD_W'(base_w + CW'(pos) + CW'(1));
            end
            ACT_FREE: begin
                item_we = in_range;
                item_ok = in_range;
                wr_word = rd_word_reg & ~(WORD_BITS'(1) << bit_pos);
            end
            ACT_MARK: begin
                item_we = in_range;
                item_ok = in_range;
                wr_word = rd_word_reg | (WORD_BITS'(1) << bit_pos);
            end
            default: ;
        endcase
    end

    assign status.done       = item_done;
    assign status.clear_last = clr_addr_reg == WA'(NUM_WORDS - 1);

    always_comb begin
        map_size_next = map_size_reg;
        free_cnt_next = free_cnt_reg;
        hint_next     = hint_reg;
        if (cfg_we) begin
            if (cfg_addr == REG_MAP_SIZE) begin
                map_size_next = cfg_wdata;
                // the bound moved: words below the hint may hold free bits now
                hint_next     = '0;
            end else begin
                free_cnt_next = cfg_wdata;
            end
        end else if (cmd.commit && item_we) begin
            case (act_reg)
                ACT_ALLOC: begin
                    hint_next = word_addr_reg;
                    if (free_cnt_reg != '0) free_cnt_next = free_cnt_reg - FIELD_W'(1);
                end
                ACT_FREE: begin
                    if (word_addr_reg < hint_reg) hint_next = word_addr_reg;
                    if (free_cnt_reg < bound) free_cnt_next = free_cnt_reg + FIELD_W'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg <= FIELD_W'(RESET_MAP_SIZE);
            free_cnt_reg <= FIELD_W'(RESET_FREE_COUNT);
            hint_reg     <= '0;
            clr_addr_reg <= '0;
        end else begin
            map_size_reg <= map_size_next;
            free_cnt_reg <= free_cnt_next;
            hint_reg     <= hint_next;
            if (cmd.clear_wr && !status.clear_last) clr_addr_reg <= clr_addr_reg + WA'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            num_reg <= in_number;
            word_addr_reg <= (in_action == ACT_ALLOC) ? hint_reg : WA'(in_idx >> WORD_LG);
        end else if (cmd.advance) begin
            word_addr_reg <= word_addr_reg + WA'(1);
        end
        if (cmd.commit) begin
            alloc_num_reg <= item_num;
            ok_reg        <= item_ok;
            free_left_reg <= free_cnt_next;
        end
    end

    assign mem_we    = cmd.clear_wr || (cmd.commit && item_we);
    assign mem_waddr = cmd.clear_wr ? clr_addr_reg : word_addr_reg;
    assign mem_wdata = cmd.clear_wr ? '0 : wr_word;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.rd) rd_word_reg <= mem[word_addr_reg];
    end

    assign m_tdata = {
        {(M_TDATA_W - 2 * FIELD_W - 1){1'b0}},
        free_left_reg, ok_reg, alloc_num_reg
    };

endmodule

FILE: hw/rtl/bitmap_number_allocator.sv
// Bitmap first-free allocator. Free and mark read one map word, then commit to the output.
// Allocate scans words from the hint until one has a free bit or the last word is reached;
// each word costs one memory read and one priority-encode step (32 bits per word).
// A new request is taken no earlier than the cycle after the previous one commits its result.
// Reset clears the map in a pass over its ceil(MAP_BITS/32) words (256 at default size),
// during which s_tready stays low; registers reset to map_size 8192, free count 8192.
module bitmap_number_allocator
    import bna_pkg::*;
#(
    parameter int MAP_BITS = DEF_MAP_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action[1:0], number[15:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // allocated_number[13:0], ok[14], free_left[28:15]
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [FIELD_W-1:0]   cfg_wdata
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    bna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bna_dp #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    a_commit_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result committed while output register still full");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.rd)
        else $error("accepted transfer not followed by a map read");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s_tready)
        else $error("input ready during map clearing pass");

    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("output valid raised without a commit");

    a_fail_zero_number: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[FIELD_W]) |-> (m_tdata[FIELD_W-1:0] == '0))
        else $error("failed request carries a nonzero number");
`endif

endmodule
